/* src/ehq_pkg.sv */
// Shared types, constants and helpers for the endpoint health quarantine block.
// No dependencies; ehq_mul, the top level and ehq_checker refer to it by scoped names.
`default_nettype none

package ehq_pkg;

  // Default sizing
  localparam int ENTRY_COUNT_DEF = 64;
  localparam int TIME_WIDTH_DEF  = 32;

  // Endpoint field span (fixed 6-bit port)
  localparam int EP_W    = 6;
  localparam int EP_SPAN = 64;

  // Q1.16 constants
  localparam int          SCORE_W  = 17;
  localparam int          COUNT_W  = 16;
  localparam int          PROD_W   = 34;
  localparam logic [16:0] ONE_Q16  = 17'h10000;
  localparam logic [16:0] HALF_Q16 = 17'h08000;

  // Penalty per error class (1.0, 0.7, 0.6)
  localparam logic [16:0] PEN_CLASS1 = 17'd65536;
  localparam logic [16:0] PEN_CLASS2 = 17'd45875;
  localparam logic [16:0] PEN_OTHER  = 17'd39322;

  // Class bounds of the error code
  localparam logic [15:0] CLASS1_LO = 16'd100;
  localparam logic [15:0] CLASS1_HI = 16'd199;
  localparam logic [15:0] CLASS2_LO = 16'd200;
  localparam logic [15:0] CLASS2_HI = 16'd299;

  // floor(x/5) == (x * 52429) >> 18 for every 16-bit x
  localparam logic [16:0] RECIP5       = 17'd52429;
  localparam int          RECIP5_SHIFT = 18;
  localparam int          LIM_W        = 14;

  localparam logic [15:0] ATT_MAX = 16'hFFFF;

  // Configuration register defaults
  localparam logic [16:0] FAIL_ALPHA_RST = 17'd3277;
  localparam logic [16:0] SUCC_ALPHA_RST = 17'd6554;
  localparam logic [15:0] MIN_ATT_RST    = 16'd20;
  localparam logic [16:0] QUAR_LVL_RST   = 17'd39322;
  localparam logic [16:0] REC_LVL_RST    = 17'd26214;
  localparam logic [15:0] COOLDOWN_RST   = 16'd60;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAIL_ALPHA = 3'd0,
    CFG_SUCC_ALPHA = 3'd1,
    CFG_MIN_ATT    = 3'd2,
    CFG_QUAR_LVL   = 3'd3,
    CFG_REC_LVL    = 3'd4,
    CFG_COOLDOWN   = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_SUCCESS = 2'd0,
    OP_FAILURE = 2'd1,
    OP_QUERY   = 2'd2,
    OP_TICK    = 2'd3
  } opcode_e;

  // Saturate a Q1.16 value at 1.0
  function automatic logic [16:0] clamp_q16(input logic [16:0] v);
    return (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

  // Penalty target from the hundreds class of the error code
  function automatic logic [16:0] penalty(input logic [15:0] code);
    logic [16:0] p;
    priority if (code >= CLASS1_LO && code <= CLASS1_HI) p = PEN_CLASS1;
    else if (code >= CLASS2_LO && code <= CLASS2_HI)     p = PEN_CLASS2;
    else                                                 p = PEN_OTHER;
    return p;
  endfunction

endpackage

`default_nettype wire

/* src/ehq_mul.sv */
// Shared 17x17 unsigned multiplier with a registered product.
// Depends on ehq_pkg for operand and product widths.
`default_nettype none

module ehq_mul (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [ehq_pkg::SCORE_W-1:0]   a_i,
  input  wire logic [ehq_pkg::SCORE_W-1:0]   b_i,
  output logic      [ehq_pkg::PROD_W-1:0]    prod_o
);

  logic [ehq_pkg::PROD_W-1:0] prod_q;

  // One product per cycle, held while idle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= ehq_pkg::PROD_W'(a_i) * ehq_pkg::PROD_W'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

/* src/ehq_table.sv */
// Endpoint state memory: one write port, one read port with registered data.
// Entry layout is set by the top level; depends on nothing else.
`default_nettype none

module ehq_table #(
  parameter int ENTRY_COUNT = 64,
  parameter int ENTRY_W     = 66
) (
  input  wire logic                           clk_i,
  input  wire logic                           rd_en_i,
  input  wire logic [$clog2(ENTRY_COUNT)-1:0] rd_addr_i,
  output logic      [ENTRY_W-1:0]             rd_data_o,
  input  wire logic                           wr_en_i,
  input  wire logic [$clog2(ENTRY_COUNT)-1:0] wr_addr_i,
  input  wire logic [ENTRY_W-1:0]             wr_data_i
);

  logic [ENTRY_W-1:0] mem_q [ENTRY_COUNT];
  logic [ENTRY_W-1:0] rd_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

/* src/endpoint_health_quarantine.sv */
// Each accepted transaction steps through READ, MUL1, MUL2, MUL3 and UPD; UPD
// waits while the previous result is held by out_stall_i. No new transaction is
// taken before UPD ends; the shared multiplier makes three passes per item
// (cooldown/5, decay product, penalty product) ahead of write-back. Reset:
// asynchronous, active low; a clearing pass then writes every memory entry,
// with in_stall_o high until it ends. Depends on ehq_pkg, ehq_mul and ehq_table.
`default_nettype none

module endpoint_health_quarantine #(
  parameter int ENTRY_COUNT = ehq_pkg::ENTRY_COUNT_DEF,
  parameter int TIME_WIDTH  = ehq_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // input channel
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [1:0]                         opcode_i,
  input  wire logic [ehq_pkg::EP_W-1:0]           endpoint_i,
  input  wire logic [15:0]                        error_code_i,
  input  wire logic signed [14:0]                 jitter_offset_i,
  // result channel
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    avoid_o,
  output logic                                    probe_granted_o,
  output logic                                    is_healthy_o,
  output logic [ehq_pkg::SCORE_W-1:0]             score_o,
  // configuration write port
  input  wire logic                               cfg_we_i,
  input  wire logic [ehq_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [ehq_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int IDX_W   = $clog2(ENTRY_COUNT);
  localparam int ENTRY_W = TIME_WIDTH + 1 + ehq_pkg::SCORE_W + ehq_pkg::COUNT_W;
  localparam int HLT_BIT = ehq_pkg::SCORE_W + ehq_pkg::COUNT_W;
  localparam int DL_LSB  = HLT_BIT + 1;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_MUL1  = 7'b0001000,
    S_MUL2  = 7'b0010000,
    S_MUL3  = 7'b0100000,
    S_UPD   = 7'b1000000
  } state_e;

  // Endpoint index modulo ENTRY_COUNT, a constant lookup over the 6-bit field
  function automatic logic [IDX_W-1:0] ep_wrap(input logic [ehq_pkg::EP_W-1:0] ep);
    logic [IDX_W-1:0] res;
    int               r;
    res = '0;
    r   = 0;
    for (int i = 0; i < ehq_pkg::EP_SPAN; i++) begin
      if (ehq_pkg::EP_W'(i) == ep) res = IDX_W'(r);
      if (r == ENTRY_COUNT - 1) r = 0;
      else r = r + 1;
    end
    return res;
  endfunction

  state_e state_q, state_d;
  logic [IDX_W-1:0] clr_q;

  // configuration registers
  logic [16:0] fail_alpha_q, succ_alpha_q, quar_lvl_q, rec_lvl_q;
  logic [15:0] min_att_q, cooldown_q;

  // latched transaction
  ehq_pkg::opcode_e   op_q;
  logic [IDX_W-1:0]   idx_q;
  logic [15:0]        code_q;
  logic signed [14:0] jit_q;

  // working registers
  logic [16:0]                 cool_q;
  logic [ehq_pkg::PROD_W-1:0]  acc_q;
  logic [16:0]                 score_q;
  logic [TIME_WIDTH-1:0]       time_now_q;

  // result registers
  logic        out_valid_q, avoid_q, probe_q, hlt_out_q;
  logic [16:0] score_out_q;

  logic accept, upd_go;
  assign accept = in_valid_i && (state_q == S_IDLE);
  assign upd_go = (state_q == S_UPD) && (!out_valid_q || !out_stall_i);

  // ---------------- shared multiplier ----------------
  logic                       mul_en;
  logic [16:0]                mul_a, mul_b, alpha_eff;
  logic [ehq_pkg::PROD_W-1:0] prod;

  assign alpha_eff = (op_q == ehq_pkg::OP_FAILURE) ? ehq_pkg::clamp_q16(fail_alpha_q)
                                                   : ehq_pkg::clamp_q16(succ_alpha_q);

  ehq_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // ---------------- endpoint memory ----------------
  logic [ENTRY_W-1:0] rd_data, wr_data;
  logic [IDX_W-1:0]   wr_addr;
  logic               wr_en;

  ehq_table #(
    .ENTRY_COUNT (ENTRY_COUNT),
    .ENTRY_W     (ENTRY_W)
  ) u_table (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (ep_wrap(endpoint_i)),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  logic [15:0]           rd_att;
  logic [16:0]           rd_score;
  logic                  rd_hlt;
  logic [TIME_WIDTH-1:0] rd_dl;

  assign rd_att   = rd_data[ehq_pkg::COUNT_W-1:0];
  assign rd_score = rd_data[HLT_BIT-1:ehq_pkg::COUNT_W];
  assign rd_hlt   = rd_data[HLT_BIT];
  assign rd_dl    = rd_data[ENTRY_W-1:DL_LSB];

  // ---------------- multiplier operand select ----------------
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      S_READ: begin
        mul_a = {1'b0, cooldown_q};
        mul_b = ehq_pkg::RECIP5;
      end
      S_MUL1: begin
        mul_a = ehq_pkg::ONE_Q16 - alpha_eff;
        mul_b = rd_score;
      end
      S_MUL2: begin
        mul_a = alpha_eff;
        mul_b = (op_q == ehq_pkg::OP_FAILURE) ? ehq_pkg::penalty(code_q) : '0;
      end
      S_CLEAR, S_IDLE, S_MUL3, S_UPD: begin
        mul_en = 1'b0;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // ---------------- jitter clamp (MUL1) ----------------
  logic signed [15:0] lim_s, jit_s, jit_c;
  logic signed [17:0] cool_sum;

  always_comb begin
    lim_s = signed'({2'b00, prod[ehq_pkg::RECIP5_SHIFT+ehq_pkg::LIM_W-1:ehq_pkg::RECIP5_SHIFT]});
    jit_s = {jit_q[14], jit_q};
    if (jit_s > lim_s)       jit_c = lim_s;
    else if (jit_s < -lim_s) jit_c = -lim_s;
    else                     jit_c = jit_s;
    cool_sum = signed'({2'b00, cooldown_q}) + {{2{jit_c[15]}}, jit_c};
  end

  // ---------------- score sum (MUL3) ----------------
  logic [ehq_pkg::PROD_W:0] score_sum;
  assign score_sum = {1'b0, acc_q} + {1'b0, prod}
                   + (ehq_pkg::PROD_W+1)'(ehq_pkg::HALF_Q16);

  // ---------------- entry update (UPD) ----------------
  logic [16:0]           q_lvl, r_clamp, r_lvl, scr_new;
  logic [15:0]           att_new;
  logic                  hlt_new, avoid_d, probe_d;
  logic [TIME_WIDTH-1:0] dl_new, next_dl;

  always_comb begin
    q_lvl   = ehq_pkg::clamp_q16(quar_lvl_q);
    r_clamp = ehq_pkg::clamp_q16(rec_lvl_q);
    r_lvl   = (r_clamp > q_lvl) ? q_lvl : r_clamp;
    next_dl = time_now_q + TIME_WIDTH'(cool_q);
    att_new = rd_att;
    scr_new = rd_score;
    hlt_new = rd_hlt;
    dl_new  = rd_dl;
    avoid_d = 1'b0;
    probe_d = 1'b0;
    unique case (op_q)
      ehq_pkg::OP_SUCCESS, ehq_pkg::OP_FAILURE: begin
        if (rd_att != ehq_pkg::ATT_MAX) att_new = rd_att + 16'd1;
        scr_new = score_q;
        // failure while quarantined re-arms the probe window
        if (op_q == ehq_pkg::OP_FAILURE && !rd_hlt) dl_new = next_dl;
        if (att_new >= min_att_q) begin
          if (rd_hlt && scr_new >= q_lvl) begin
            hlt_new = 1'b0;
            dl_new  = next_dl;
          end else if (!rd_hlt && scr_new <= r_lvl) begin
            hlt_new = 1'b1;
            dl_new  = '0;
          end
        end
      end
      ehq_pkg::OP_QUERY: begin
        if (!rd_hlt) begin
          if (time_now_q >= rd_dl) begin
            dl_new  = next_dl;
            probe_d = 1'b1;
          end else begin
            avoid_d = 1'b1;
          end
        end
      end
      ehq_pkg::OP_TICK: begin
      end
      default: begin
      end
    endcase
  end

  // memory write: clearing pass or write-back
  always_comb begin
    if (state_q == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_q;
      wr_data = {{TIME_WIDTH{1'b0}}, 1'b1, {ehq_pkg::SCORE_W{1'b0}},
                 {ehq_pkg::COUNT_W{1'b0}}};
    end else begin
      wr_en   = upd_go;
      wr_addr = idx_q;
      wr_data = {dl_new, hlt_new, scr_new, att_new};
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == IDX_W'(ENTRY_COUNT - 1)) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_READ;
      S_READ:  state_d = S_MUL1;
      S_MUL1:  state_d = S_MUL2;
      S_MUL2:  state_d = S_MUL3;
      S_MUL3:  state_d = S_UPD;
      S_UPD:   if (upd_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + IDX_W'(1);
    end
  end

  // ---------------- transaction and working registers ----------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= ehq_pkg::opcode_e'(opcode_i);
      idx_q  <= ep_wrap(endpoint_i);
      code_q <= error_code_i;
      jit_q  <= jitter_offset_i;
    end
    if (state_q == S_MUL1) cool_q  <= cool_sum[16:0];
    if (state_q == S_MUL2) acc_q   <= prod;
    if (state_q == S_MUL3) score_q <= score_sum[32:16];
  end

  // ---------------- time base ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_now_q <= '0;
    end else if (upd_go && op_q == ehq_pkg::OP_TICK) begin
      time_now_q <= time_now_q + TIME_WIDTH'(1);
    end
  end

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_alpha_q <= ehq_pkg::FAIL_ALPHA_RST;
      succ_alpha_q <= ehq_pkg::SUCC_ALPHA_RST;
      min_att_q    <= ehq_pkg::MIN_ATT_RST;
      quar_lvl_q   <= ehq_pkg::QUAR_LVL_RST;
      rec_lvl_q    <= ehq_pkg::REC_LVL_RST;
      cooldown_q   <= ehq_pkg::COOLDOWN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ehq_pkg::CFG_FAIL_ALPHA: fail_alpha_q <= cfg_data_i;
        ehq_pkg::CFG_SUCC_ALPHA: succ_alpha_q <= cfg_data_i;
        ehq_pkg::CFG_MIN_ATT:    min_att_q    <= cfg_data_i[15:0];
        ehq_pkg::CFG_QUAR_LVL:   quar_lvl_q   <= cfg_data_i;
        ehq_pkg::CFG_REC_LVL:    rec_lvl_q    <= cfg_data_i;
        ehq_pkg::CFG_COOLDOWN:   cooldown_q   <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (upd_go) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_go) begin
      avoid_q     <= avoid_d;
      probe_q     <= probe_d;
      hlt_out_q   <= hlt_new;
      score_out_q <= scr_new;
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign avoid_o         = avoid_q;
  assign probe_granted_o = probe_q;
  assign is_healthy_o    = hlt_out_q;
  assign score_o         = score_out_q;

endmodule

`default_nettype wire

/* src/ehq_checker.sv */
// Port-level checks for endpoint_health_quarantine, attached by bind.
// Depends on ehq_pkg for the score width and the Q1.16 unit.
`default_nettype none

module ehq_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_valid_i,
  input wire logic                             in_stall_o,
  input wire logic                             out_valid_o,
  input wire logic                             out_stall_i,
  input wire logic                             avoid_o,
  input wire logic                             probe_granted_o,
  input wire logic                             is_healthy_o,
  input wire logic [ehq_pkg::SCORE_W-1:0]      score_o
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(avoid_o)
      && $stable(probe_granted_o) && $stable(is_healthy_o) && $stable(score_o))
    else $error("result changed while stalled");

  // one transaction at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while an item is in flight");

  // refuse and probe are exclusive
  a_avoid_probe_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(avoid_o && probe_granted_o))
    else $error("avoid and probe both set");

  // refusals and probes only concern quarantined endpoints
  a_gate_unhealthy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (avoid_o || probe_granted_o) |-> !is_healthy_o)
    else $error("avoid or probe on a healthy endpoint");

  // score never exceeds 1.0
  a_score_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> score_o <= ehq_pkg::ONE_Q16)
    else $error("score above 1.0");

endmodule

bind endpoint_health_quarantine ehq_checker u_ehq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .avoid_o         (avoid_o),
  .probe_granted_o (probe_granted_o),
  .is_healthy_o    (is_healthy_o),
  .score_o         (score_o)
);

`default_nettype wire
